@@ sv/kspwm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kspwm_pkg: shared types and constants of the knob smoothed PWM setup block
// Field widths, register map, reset values, sequencer states and the request
// and response bundles of the serial arithmetic units.
// ----------------------------------------------------------------------------
package kspwm_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int FREQ_W   = 20;
    localparam int CLK_W    = 27;
    localparam int DUTY_W   = 7;
    localparam int TOP_W    = 16;

    // serial unit widths
    localparam int DIV_W   = 32;
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 10;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // arithmetic constants
    localparam int KNOB_FULL      = 1023;
    localparam int DUTY_SCALE     = 100;
    localparam int PRESCALE_SHIFT = 8;
    localparam int TOP_MAX        = 65535;

    // register map (index = paddr[3:2])
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_CLOCK_HZ = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FREQ_MIN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FREQ_MAX = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_THRESH   = 2'd3;

    // register reset values
    localparam int CLOCK_HZ_RST = 16000000;
    localparam int FREQ_MIN_RST = 1;
    localparam int FREQ_MAX_RST = 10000;
    localparam int THRESH_RST   = 200;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_AVG,
        S_DMAP,
        S_FMUL,
        S_FDIV,
        S_TSTART,
        S_TDIV,
        S_CMUL,
        S_CDIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] mcand;
        logic [MUL_B_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MUL_P_W-1:0] product;
    } t_mul_rsp;

endpackage
`default_nettype wire

@@ sv/kspwm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kspwm_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module kspwm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 100
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/kspwm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kspwm_div: bit-serial restoring divider
// Shifts one dividend bit in and one quotient bit out per cycle; done pulses
// after DIV_W steps and the quotient holds until the next start.
// ----------------------------------------------------------------------------
module kspwm_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire kspwm_pkg::t_div_req i_req,
    output kspwm_pkg::t_div_rsp      o_rsp
);
    import kspwm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_dvs, n_dvs;
    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_W);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            // keep the difference when there is no borrow
            if (!w_diff[DIV_W]) begin
                n_rem = w_diff[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

@@ sv/kspwm_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kspwm_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle, shifting the partial product right;
// done pulses after MUL_B_W steps and the product holds until the next start.
// ----------------------------------------------------------------------------
module kspwm_mul (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire kspwm_pkg::t_mul_req i_req,
    output kspwm_pkg::t_mul_rsp      o_rsp
);
    import kspwm_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [MUL_A_W:0]   r_hi, n_hi;
    logic [MUL_B_W-1:0] r_lo, n_lo;
    logic [MUL_A_W-1:0] r_mcand, n_mcand;
    logic [MUL_A_W:0]   w_hi_add;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_mcand  = r_mcand;
        w_hi_add = r_lo[0] ? (r_hi + {1'b0, r_mcand}) : r_hi;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = CNT_W'(MUL_B_W);
            n_hi    = '0;
            n_lo    = i_req.mplier;
            n_mcand = i_req.mcand;
        end else if (r_busy) begin
            {n_hi, n_lo} = {1'b0, w_hi_add, r_lo[MUL_B_W-1:1]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_mcand <= n_mcand;
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = {r_hi[MUL_A_W-1:0], r_lo};

endmodule
`default_nettype wire

@@ sv/knob_smoothed_pwm_setup.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// knob_smoothed_pwm_setup: boxcar-smoothed knobs to PWM timer settings
// Averages frequency and duty knob samples over WINDOW readings and, when the
// smoothed frequency or mapped duty changes, sets timer top, compare, prescaler.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   input    | i_valid / o_stall  | i_req_type, i_knob_sample
//   result   | o_valid / i_stall  | o_period_top, o_compare_value,
//            |                    | o_slow_prescale, o_out_of_range
//   config   | APB psel/penable   | paddr, pwdata, prdata (pready tied 1)
//
// One item at a time. Each item runs through up to four divisions on the
// 32-step shared serial divider and two 10-step serial multiplications, and
// an item with a result also waits for any stalled earlier result.
// Reset clears the sums and ring pointers at once; unwritten ring entries
// read as zero through a per-ring wrap flag, so there is no clearing pass.
// A stalled result holds the sequencer in its last state until transfer.
// ----------------------------------------------------------------------------
module knob_smoothed_pwm_setup #(
    parameter int WINDOW = 100
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_req_type,
    input  wire logic [9:0]  i_knob_sample,
    // results
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [15:0] o_period_top,
    output logic      [15:0] o_compare_value,
    output logic             o_slow_prescale,
    output logic             o_out_of_range,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import kspwm_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int DPROD_W = SAMPLE_W + DUTY_W;

    // configuration registers
    logic [CLK_W-1:0]  r_clk_hz, n_clk_hz;
    logic [FREQ_W-1:0] r_fmin, n_fmin;
    logic [FREQ_W-1:0] r_fmax, n_fmax;
    logic [FREQ_W-1:0] r_thr, n_thr;

    // control state
    t_state            r_state, n_state;
    logic [SUM_W-1:0]  r_fsum, n_fsum;
    logic [SUM_W-1:0]  r_dsum, n_dsum;
    logic [SLOT_W-1:0] r_fslot, n_fslot;
    logic [SLOT_W-1:0] r_dslot, n_dslot;
    logic              r_fwrap, n_fwrap;
    logic              r_dwrap, n_dwrap;
    logic [SAMPLE_W-1:0] r_last_favg, n_last_favg;
    logic [FREQ_W-1:0] r_cur_freq, n_cur_freq;
    logic [DUTY_W-1:0] r_cur_duty, n_cur_duty;
    logic              r_out_valid, n_out_valid;

    // item payload and intermediate values
    logic                r_sel, n_sel;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic [TOP_W-1:0]    r_top, n_top;
    logic                r_flag, n_flag;
    logic                r_slow, n_slow;
    logic [TOP_W-1:0]    r_period_top, n_period_top;
    logic [TOP_W-1:0]    r_compare, n_compare;
    logic                r_slow_out, n_slow_out;
    logic                r_flag_out, n_flag_out;

    // ring memories
    logic                w_fwe, w_dwe;
    logic [SAMPLE_W-1:0] w_frd, w_drd;

    // arithmetic units
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    // datapath
    logic [SLOT_W-1:0]   w_slot;
    logic [SLOT_W-1:0]   w_slot_next;
    logic [SAMPLE_W-1:0] w_old;
    logic [SUM_W-1:0]    w_new_sum;
    logic [SAMPLE_W-1:0] w_avg;
    logic [DPROD_W-1:0]  w_duty_prod;
    logic                w_fall;
    logic [FREQ_W-1:0]   w_span;
    logic [FREQ_W-1:0]   w_fstep;
    logic [FREQ_W-1:0]   w_new_freq;
    logic [DUTY_W-1:0]   w_new_duty;
    logic                w_slow;
    logic [TOP_W-1:0]    w_top_calc;
    logic                w_top_sat;
    logic                w_cfg_wr;

    kspwm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_freq_ring (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (r_fslot),
        .i_wdata (r_sample),
        .i_raddr (r_fslot),
        .o_rdata (w_frd)
    );

    kspwm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_duty_ring (
        .i_clk   (i_clk),
        .i_we    (w_dwe),
        .i_waddr (r_dslot),
        .i_wdata (r_sample),
        .i_raddr (r_dslot),
        .o_rdata (w_drd)
    );

    kspwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    kspwm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_comb begin
        n_clk_hz = r_clk_hz;
        n_fmin   = r_fmin;
        n_fmax   = r_fmax;
        n_thr    = r_thr;
        if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_CLOCK_HZ: n_clk_hz = pwdata[CLK_W-1:0];
                REG_FREQ_MIN: n_fmin   = pwdata[FREQ_W-1:0];
                REG_FREQ_MAX: n_fmax   = pwdata[FREQ_W-1:0];
                REG_THRESH:   n_thr    = pwdata[FREQ_W-1:0];
                default:      n_thr    = r_thr;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CLOCK_HZ: prdata = 32'(r_clk_hz);
            REG_FREQ_MIN: prdata = 32'(r_fmin);
            REG_FREQ_MAX: prdata = 32'(r_fmax);
            REG_THRESH:   prdata = 32'(r_thr);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    assign w_slot      = r_sel ? r_dslot : r_fslot;
    assign w_slot_next = (w_slot == SLOT_W'(WINDOW - 1)) ? '0 : w_slot + 1'b1;
    // entries not yet written since reset read as zero
    assign w_old       = r_sel ? (r_dwrap ? w_drd : '0) : (r_fwrap ? w_frd : '0);
    assign w_new_sum   = (r_sel ? r_dsum : r_fsum) - SUM_W'(w_old) + SUM_W'(r_sample);
    assign w_avg       = div_rsp.quotient[SAMPLE_W-1:0];
    assign w_duty_prod = DPROD_W'(w_avg) * DPROD_W'(DUTY_SCALE);
    assign w_fall      = r_fmax < r_fmin;
    assign w_span      = w_fall ? (r_fmin - r_fmax) : (r_fmax - r_fmin);
    assign w_fstep     = div_rsp.quotient[FREQ_W-1:0];
    assign w_new_freq  = w_fall ? (r_fmin - w_fstep) : (r_fmin + w_fstep);
    assign w_new_duty  = div_rsp.quotient[DUTY_W-1:0];
    assign w_slow      = r_cur_freq < r_thr;
    assign w_fwe       = (r_state == S_SUM) && !r_sel;
    assign w_dwe       = (r_state == S_SUM) && r_sel;

    // top = quotient - 1, zero for a zero quotient, saturate above 16 bits
    always_comb begin
        if (div_rsp.quotient == '0) begin
            w_top_calc = '0;
            w_top_sat  = 1'b0;
        end else if (div_rsp.quotient > DIV_W'(TOP_MAX + 1)) begin
            w_top_calc = TOP_W'(TOP_MAX);
            w_top_sat  = 1'b1;
        end else begin
            w_top_calc = TOP_W'(div_rsp.quotient - DIV_W'(1));
            w_top_sat  = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_fsum       = r_fsum;
        n_dsum       = r_dsum;
        n_fslot      = r_fslot;
        n_dslot      = r_dslot;
        n_fwrap      = r_fwrap;
        n_dwrap      = r_dwrap;
        n_last_favg  = r_last_favg;
        n_cur_freq   = r_cur_freq;
        n_cur_duty   = r_cur_duty;
        n_out_valid  = r_out_valid & i_stall;
        n_sel        = r_sel;
        n_sample     = r_sample;
        n_avg        = r_avg;
        n_top        = r_top;
        n_flag       = r_flag;
        n_slow       = r_slow;
        n_period_top = r_period_top;
        n_compare    = r_compare;
        n_slow_out   = r_slow_out;
        n_flag_out   = r_flag_out;
        div_req      = '0;
        mul_req      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sel    = i_req_type;
                    n_sample = i_knob_sample;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                if (r_sel) begin
                    n_dsum  = w_new_sum;
                    n_dslot = w_slot_next;
                    if (w_slot_next == '0) begin
                        n_dwrap = 1'b1;
                    end
                end else begin
                    n_fsum  = w_new_sum;
                    n_fslot = w_slot_next;
                    if (w_slot_next == '0) begin
                        n_fwrap = 1'b1;
                    end
                end
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(w_new_sum);
                div_req.divisor  = DIV_W'(WINDOW);
                n_state          = S_AVG;
            end
            S_AVG: begin
                if (div_rsp.done) begin
                    n_avg = w_avg;
                    if (r_sel) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(w_duty_prod);
                        div_req.divisor  = DIV_W'(KNOB_FULL);
                        n_state          = S_DMAP;
                    end else if (w_avg == r_last_favg) begin
                        n_state = S_IDLE;
                    end else begin
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = MUL_A_W'(w_span);
                        mul_req.mplier = MUL_B_W'(w_avg);
                        n_state        = S_FMUL;
                    end
                end
            end
            S_DMAP: begin
                if (div_rsp.done) begin
                    if (w_new_duty == r_cur_duty) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur_duty = w_new_duty;
                        n_state    = S_TSTART;
                    end
                end
            end
            S_FMUL: begin
                if (mul_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(mul_rsp.product);
                    div_req.divisor  = DIV_W'(KNOB_FULL);
                    n_state          = S_FDIV;
                end
            end
            S_FDIV: begin
                if (div_rsp.done) begin
                    n_cur_freq  = w_new_freq;
                    n_last_favg = r_avg;
                    n_state     = S_TSTART;
                end
            end
            S_TSTART: begin
                n_slow = w_slow;
                n_flag = 1'b0;
                if (r_cur_freq == '0) begin
                    // zero frequency: saturate without dividing
                    n_top          = TOP_W'(TOP_MAX);
                    n_flag         = 1'b1;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = MUL_A_W'(TOP_MAX);
                    mul_req.mplier = MUL_B_W'(r_cur_duty);
                    n_state        = S_CMUL;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(r_clk_hz);
                    div_req.divisor  = w_slow
                        ? DIV_W'({r_cur_freq, PRESCALE_SHIFT'(0)})
                        : DIV_W'(r_cur_freq);
                    n_state          = S_TDIV;
                end
            end
            S_TDIV: begin
                if (div_rsp.done) begin
                    n_top          = w_top_calc;
                    n_flag         = w_top_sat;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = MUL_A_W'(w_top_calc);
                    mul_req.mplier = MUL_B_W'(r_cur_duty);
                    n_state        = S_CMUL;
                end
            end
            S_CMUL: begin
                if (mul_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(mul_rsp.product);
                    div_req.divisor  = DIV_W'(DUTY_SCALE);
                    n_state          = S_CDIV;
                end
            end
            S_CDIV: begin
                if (div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_period_top = r_top;
                    n_compare    = div_rsp.quotient[TOP_W-1:0];
                    n_slow_out   = r_slow;
                    n_flag_out   = r_flag;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz    <= CLK_W'(CLOCK_HZ_RST);
            r_fmin      <= FREQ_W'(FREQ_MIN_RST);
            r_fmax      <= FREQ_W'(FREQ_MAX_RST);
            r_thr       <= FREQ_W'(THRESH_RST);
            r_state     <= S_IDLE;
            r_fsum      <= '0;
            r_dsum      <= '0;
            r_fslot     <= '0;
            r_dslot     <= '0;
            r_fwrap     <= 1'b0;
            r_dwrap     <= 1'b0;
            r_last_favg <= '0;
            r_cur_freq  <= FREQ_W'(FREQ_MIN_RST);
            r_cur_duty  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clk_hz    <= n_clk_hz;
            r_fmin      <= n_fmin;
            r_fmax      <= n_fmax;
            r_thr       <= n_thr;
            r_state     <= n_state;
            r_fsum      <= n_fsum;
            r_dsum      <= n_dsum;
            r_fslot     <= n_fslot;
            r_dslot     <= n_dslot;
            r_fwrap     <= n_fwrap;
            r_dwrap     <= n_dwrap;
            r_last_favg <= n_last_favg;
            r_cur_freq  <= n_cur_freq;
            r_cur_duty  <= n_cur_duty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel        <= n_sel;
        r_sample     <= n_sample;
        r_avg        <= n_avg;
        r_top        <= n_top;
        r_flag       <= n_flag;
        r_slow       <= n_slow;
        r_period_top <= n_period_top;
        r_compare    <= n_compare;
        r_slow_out   <= n_slow_out;
        r_flag_out   <= n_flag_out;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_period_top    = r_period_top;
    assign o_compare_value = r_compare;
    assign o_slow_prescale = r_slow_out;
    assign o_out_of_range  = r_flag_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the emit state");

    a_compare_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_compare_value <= o_period_top))
        else $error("compare value above period top");

    a_flag_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_period_top == TOP_W'(TOP_MAX)))
        else $error("out of range without saturated top");

endmodule
`default_nettype wire

@@ dv/knob_smoothed_pwm_setup_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// knob_smoothed_pwm_setup_test: self-checking bench for the knob PWM setup
// Feeds frequency and duty knob samples through the valid/stall input channel
// under several register settings and checks every timer result against an
// in-bench model of the boxcar averages and timer arithmetic, with random
// sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module knob_smoothed_pwm_setup_test;
    import kspwm_pkg::*;

    localparam int WINDOW_LEN    = 100;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic KNOB_FREQ   = 1'b0;
    localparam logic KNOB_DUTY   = 1'b1;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        logic [TOP_W-1:0] top;
        logic [TOP_W-1:0] cmp;
        logic             slow;
        logic             sat;
    } t_timer_setting;

    // Averages both knobs and predicts the timer values a refresh produces.
    class pwm_scoreboard;
        logic [CLK_W-1:0]    clock_hz;
        logic [FREQ_W-1:0]   f_lo;
        logic [FREQ_W-1:0]   f_hi;
        logic [FREQ_W-1:0]   slow_below;
        logic [SAMPLE_W-1:0] hist [2][WINDOW_LEN];
        int unsigned         total [2];
        int unsigned         pos [2];
        int unsigned         last_avg [2];
        logic [FREQ_W-1:0]   cur_freq;
        int unsigned         cur_duty;
        t_timer_setting      expected_q [$];
        int                  errors;

        function new();
            clock_hz   = CLK_W'(CLOCK_HZ_RST);
            f_lo       = FREQ_W'(FREQ_MIN_RST);
            f_hi       = FREQ_W'(FREQ_MAX_RST);
            slow_below = FREQ_W'(THRESH_RST);
            for (int k = 0; k < 2; k++) begin
                for (int j = 0; j < WINDOW_LEN; j++) hist[k][j] = '0;
                total[k]    = 0;
                pos[k]      = 0;
                last_avg[k] = 0;
            end
            cur_freq = FREQ_W'(FREQ_MIN_RST);
            cur_duty = 0;
            errors   = 0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_CLOCK_HZ: clock_hz   = value[CLK_W-1:0];
                REG_FREQ_MIN: f_lo       = value[FREQ_W-1:0];
                REG_FREQ_MAX: f_hi       = value[FREQ_W-1:0];
                REG_THRESH:   slow_below = value[FREQ_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned push_sample(int k, logic [SAMPLE_W-1:0] s);
            total[k] = total[k] - hist[k][pos[k]] + s;
            hist[k][pos[k]] = s;
            pos[k] = (pos[k] + 1) % WINDOW_LEN;
            return total[k] / WINDOW_LEN;
        endfunction

        function int unsigned duty_of(int unsigned avg);
            return (avg * DUTY_SCALE) / KNOB_FULL;
        endfunction

        function t_timer_setting timer_values();
            longint unsigned f;
            longint unsigned p;
            longint unsigned q;
            longint unsigned top;
            t_timer_setting  r;
            f      = cur_freq;
            r.slow = (f < slow_below);
            p      = r.slow ? (64'd1 << PRESCALE_SHIFT) : 64'd1;
            r.sat  = 1'b0;
            if (f == 0) begin
                top   = TOP_MAX;
                r.sat = 1'b1;
            end else begin
                q   = clock_hz / (p * f);
                top = (q == 0) ? 64'd0 : q - 1;
                if (top > TOP_MAX) begin
                    top   = TOP_MAX;
                    r.sat = 1'b1;
                end
            end
            r.top = top[TOP_W-1:0];
            q     = (top * cur_duty) / DUTY_SCALE;
            r.cmp = q[TOP_W-1:0];
            return r;
        endfunction

        function void note_input(logic req, logic [SAMPLE_W-1:0] s);
            int unsigned avg;
            longint      mapped;
            if (req == KNOB_FREQ) begin
                avg = push_sample(0, s);
                if (avg == last_avg[0]) return;
                mapped = (longint'(avg) * (longint'(f_hi) - longint'(f_lo))) / KNOB_FULL
                         + longint'(f_lo);
                if (mapped < 0) mapped = 0;
                cur_freq    = mapped[FREQ_W-1:0];
                last_avg[0] = avg;
            end else begin
                avg = push_sample(1, s);
                if (duty_of(avg) == duty_of(last_avg[1])) return;
                cur_duty    = duty_of(avg);
                last_avg[1] = avg;
            end
            expected_q.push_back(timer_values());
        endfunction

        function void compare_field(string what, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(logic [TOP_W-1:0] top, logic [TOP_W-1:0] cmp,
                                   logic slow, logic sat);
            t_timer_setting want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual top %0d cmp %0d",
                         $time, top, cmp);
                return;
            end
            want = expected_q.pop_front();
            compare_field("period_top", want.top, top);
            compare_field("compare_value", want.cmp, cmp);
            compare_field("slow_prescale", want.slow, slow);
            compare_field("out_of_range", want.sat, sat);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_req_type = 1'b0;
    logic [SAMPLE_W-1:0]  i_knob_sample = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [TOP_W-1:0]     o_period_top;
    logic [TOP_W-1:0]     o_compare_value;
    logic                 o_slow_prescale;
    logic                 o_out_of_range;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [3:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    pwm_scoreboard sb;
    int            cycle_count = 0;
    int            burst_left = 0;
    t_stall_mode   stall_mode = STALL_NONE;
    int            stall_hold = 0;

    knob_smoothed_pwm_setup #(.WINDOW(WINDOW_LEN)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_knob_sample   (i_knob_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_period_top    (o_period_top),
        .o_compare_value (o_compare_value),
        .o_slow_prescale (o_slow_prescale),
        .o_out_of_range  (o_out_of_range),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Receiver: pick a random stall pattern and hold it for a random span before switching.
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_hold <= $urandom_range(50, 400);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_LIGHT:    i_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: i_stall <= ((cycle_count % 7) < 4);
            default:        i_stall <= ($urandom_range(0, 99) < 85);
        endcase
    end

    // Check results before noting a new transfer on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result(o_period_top, o_compare_value, o_slow_prescale,
                                o_out_of_range);
            if (i_valid && !o_stall)
                sb.note_input(i_req_type, i_knob_sample);
        end
    end

    task automatic send_item(input logic req, input logic [SAMPLE_W-1:0] s);
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_knob_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // drop valid for a gap, then start a new burst
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] clk_hz, input logic [31:0] f_lo,
                             input logic [31:0] f_hi, input logic [31:0] thresh);
        drain_results();
        write_register(REG_CLOCK_HZ, clk_hz);
        write_register(REG_FREQ_MIN, f_lo);
        write_register(REG_FREQ_MAX, f_hi);
        write_register(REG_THRESH, thresh);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return SAMPLE_W'(KNOB_FULL);
            default: return SAMPLE_W'($urandom_range(0, KNOB_FULL));
        endcase
    endfunction

    // Segments: mostly a knob held near a level, some pure noise.
    task automatic run_random(input int count);
        int                  sent;
        int                  seg_len;
        int                  kind;
        int                  spread;
        int                  v;
        int                  j;
        logic                mixed;
        logic                main_knob;
        logic                req;
        logic [SAMPLE_W-1:0] level [2];
        sent = 0;
        while (sent < count) begin
            seg_len   = $urandom_range(5, 250);
            kind      = $urandom_range(0, 9);
            level[0]  = pick_level();
            level[1]  = pick_level();
            case ($urandom_range(0, 2))
                0:       spread = 0;
                1:       spread = 8;
                default: spread = 200;
            endcase
            mixed     = ($urandom_range(0, 2) == 0);
            main_knob = 1'($urandom_range(0, 1));
            for (j = 0; j < seg_len && sent < count; j++) begin
                if (kind < 2) begin
                    send_item(1'($urandom_range(0, 1)),
                              SAMPLE_W'($urandom_range(0, KNOB_FULL)));
                end else begin
                    if (mixed)
                        req = 1'($urandom_range(0, 1));
                    else
                        req = ($urandom_range(0, 9) < 8) ? main_knob : !main_knob;
                    v = int'(level[req]) + int'($urandom_range(0, 2 * spread)) - spread;
                    if (v < 0) v = 0;
                    if (v > KNOB_FULL) v = KNOB_FULL;
                    send_item(req, v[SAMPLE_W-1:0]);
                end
                sent++;
                if ($urandom_range(0, 299) == 0) drain_results();
            end
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int k;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opening items under reset settings: field extremes on both knobs
        send_item(KNOB_FREQ, 10'd1023);
        send_item(KNOB_FREQ, 10'd1023);
        send_item(KNOB_FREQ, 10'd0);
        send_item(KNOB_FREQ, 10'd1023);
        send_item(KNOB_DUTY, 10'd1023);
        send_item(KNOB_DUTY, 10'd1023);
        send_item(KNOB_DUTY, 10'd1023);
        send_item(KNOB_DUTY, 10'd0);
        send_item(KNOB_DUTY, 10'd1023);
        send_item(KNOB_FREQ, 10'd512);
        send_item(KNOB_DUTY, 10'd511);
        send_item(KNOB_FREQ, 10'd1);
        send_item(KNOB_DUTY, 10'd1022);
        send_item(KNOB_FREQ, 10'd682);
        send_item(KNOB_DUTY, 10'd341);
        send_item(KNOB_FREQ, 10'd1023);

        configure(32'd16000000, 32'd1, 32'd10000, 32'd200);
        run_random(150);
        // falling mapping, everything but the top frequency below the threshold
        configure(32'd100000000, 32'd1000000, 32'd1, 32'd1000000);
        run_random(120);
        // clock slower than one timer tick
        configure(32'd1, 32'd1, 32'd1000000, 32'd1);
        run_random(80);
        // zero frequency saturates the top
        configure(32'd16000000, 32'd0, 32'd0, 32'd200);
        run_random(60);
        // zero clock
        configure(32'd0, 32'd5, 32'd900, 32'd0);
        run_random(60);
        // all-ones writes, held to register widths
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(80);
        // fast clock, slow output: saturated top feeds the compare value
        configure(32'd100000000, 32'd1, 32'd60, 32'd0);
        run_random(80);
        for (k = 0; k < 4; k++) begin
            configure($urandom_range(1, 100000000), $urandom_range(1, 3000),
                      $urandom_range(1, 1000000), $urandom_range(1, 5000));
            run_random(100);
        end
        configure(32'd16000000, 32'd1, 32'd10000, 32'd200);
        run_random(120);

        drain_results();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

@@ knob_smoothed_pwm_setup.f @@
sv/kspwm_pkg.sv
sv/kspwm_ram.sv
sv/kspwm_div.sv
sv/kspwm_mul.sv
sv/knob_smoothed_pwm_setup.sv
dv/knob_smoothed_pwm_setup_test.sv
